@@ hw/rtl/rc4_pkg.sv @@
package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int PERM_DEPTH        = 256;
  localparam int PERM_AW           = 8;
  localparam int KEY_REGS          = 4;
  localparam int KEY_REG_W         = 64;
  localparam int KIDX_W            = 5;
  localparam int LEN_W             = 6;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int MAX_KEY_BYTES_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;

  localparam logic [LEN_W-1:0] KEY_LEN_RESET = 6'd32;

  typedef struct packed {
    logic load_in;
    logic ks_init;
    logic fill;
    logic ks_rd_n;
    logic ks_rd_a;
    logic ks_wr_n;
    logic ks_wr_a;
    logic gen_start;
    logic gen_rd_j;
    logic gen_wr_i;
    logic gen_wr_j;
    logic out_load;
    logic out_from_hold;
  } cmd_t;

  typedef struct packed {
    logic n_last;
  } sts_t;

endpackage

@@ hw/rtl/rc4_if.sv @@
interface rc4_in_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::BYTE_W-1:0] data_byte;
  logic                       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface rc4_out_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

@@ hw/rtl/rc4_stream_cipher.sv @@
// Channel  Dir  Payload                         Beat taken when
// in_ch    in   data_byte[7:0], restart         valid && ready
// out_ch   out  out_byte[7:0]                   valid && ready
// cfg_*    in   cfg_index[2:0], cfg_wdata[63:0] cfg_we
//
// A byte is taken only while idle; the next waits until its result is registered.
// A restart beat (or the first beat after reset) first runs the key schedule:
// a fill pass, then for each entry reads of S[n] and S[acc] and a swap, over the
// permutation RAM (one read, one write port). Reset is synchronous, active low.
// A result facing a stalled output waits in S_HOLD; no beat is taken meanwhile.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rc4_in_if.sink                         in_ch,
  rc4_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rc4_pkg::cmd_t cmd;
  rc4_pkg::sts_t sts;

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_data_byte (in_ch.data_byte),
    .out_byte     (out_ch.out_byte),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

@@ hw/rtl/rc4_ram.sv @@
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/rc4_ctrl.sv @@
module rc4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FILL    = 4'd1;
  localparam logic [3:0] S_KS_RD_N = 4'd2;
  localparam logic [3:0] S_KS_RD_A = 4'd3;
  localparam logic [3:0] S_KS_WR_N = 4'd4;
  localparam logic [3:0] S_KS_WR_A = 4'd5;
  localparam logic [3:0] S_G_RD_I  = 4'd6;
  localparam logic [3:0] S_G_RD_J  = 4'd7;
  localparam logic [3:0] S_G_WR_I  = 4'd8;
  localparam logic [3:0] S_G_WR_J  = 4'd9;
  localparam logic [3:0] S_HOLD    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       keyed_r, keyed_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    keyed_nxt = keyed_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_restart || !keyed_r) begin
            cmd.ks_init = 1'b1;
            state_nxt   = S_FILL;
          end else begin
            cmd.gen_start = 1'b1;
            state_nxt     = S_G_RD_J;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.n_last) begin
          state_nxt = S_KS_RD_N;
        end
      end
      S_KS_RD_N: begin
        cmd.ks_rd_n = 1'b1;
        state_nxt   = S_KS_RD_A;
      end
      S_KS_RD_A: begin
        cmd.ks_rd_a = 1'b1;
        state_nxt   = S_KS_WR_N;
      end
      S_KS_WR_N: begin
        cmd.ks_wr_n = 1'b1;
        state_nxt   = S_KS_WR_A;
      end
      S_KS_WR_A: begin
        cmd.ks_wr_a = 1'b1;
        if (sts.n_last) begin
          keyed_nxt = 1'b1;
          state_nxt = S_G_RD_I;
        end else begin
          state_nxt = S_KS_RD_N;
        end
      end
      S_G_RD_I: begin
        cmd.gen_start = 1'b1;
        state_nxt     = S_G_RD_J;
      end
      S_G_RD_J: begin
        cmd.gen_rd_j = 1'b1;
        state_nxt    = S_G_WR_I;
      end
      S_G_WR_I: begin
        cmd.gen_wr_i = 1'b1;
        state_nxt    = S_G_WR_J;
      end
      S_G_WR_J: begin
        cmd.gen_wr_j = 1'b1;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_hold = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/rc4_dp.sv @@
module rc4_dp #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [rc4_pkg::BYTE_W-1:0]       in_data_byte,
  output logic [rc4_pkg::BYTE_W-1:0]       out_byte,
  input  rc4_pkg::cmd_t                    cmd,
  output rc4_pkg::sts_t                    sts
);

  localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int AW     = rc4_pkg::PERM_AW;
  localparam int BW     = rc4_pkg::BYTE_W;
  localparam int LW     = rc4_pkg::LEN_W;

  logic [rc4_pkg::KEY_REG_W-1:0] key_r [rc4_pkg::KEY_REGS];
  logic [LW-1:0]                 key_len_r;

  logic [AW-1:0]     n_r, i_r, j_r, acc_r;
  logic [KPOS_W-1:0] kpos_r;
  logic [BW-1:0]     si_r, sj_r, t_r, ks_r, data_r, out_byte_r;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [BW-1:0]             ram_wdata, ram_rdata;
  logic [rc4_pkg::KIDX_W-1:0] kidx;
  logic [BW-1:0]             key_byte;
  logic [LW-1:0]             len_eff, kpos_inc;
  logic [AW-1:0]             acc_nxt, i_inc, j_nxt, t_nxt;
  logic [BW-1:0]             ks_comb;

  rc4_ram #(
    .WIDTH (BW),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign kidx     = rc4_pkg::KIDX_W'(kpos_r);
  assign key_byte = key_r[kidx[4:3]][{kidx[2:0], 3'b000} +: BW];
  assign kpos_inc = LW'(kpos_r) + LW'(1);
  assign acc_nxt  = AW'(acc_r + ram_rdata + key_byte);
  assign i_inc    = AW'(i_r + AW'(1));
  assign j_nxt    = AW'(j_r + ram_rdata);
  assign t_nxt    = AW'(si_r + ram_rdata);
  assign sts.n_last = (n_r == {AW{1'b1}});

  always_comb begin
    if (key_len_r == '0) begin
      len_eff = LW'(1);
    end else if (key_len_r > LW'(MAX_KEY_BYTES)) begin
      len_eff = LW'(MAX_KEY_BYTES);
    end else begin
      len_eff = key_len_r;
    end
  end

  always_comb begin
    if (t_r == j_r) begin
      ks_comb = si_r;
    end else if (t_r == i_r) begin
      ks_comb = sj_r;
    end else begin
      ks_comb = ram_rdata;
    end
  end

  always_comb begin
    ram_raddr = n_r;
    if (cmd.ks_rd_n) begin
      ram_raddr = n_r;
    end else if (cmd.ks_rd_a) begin
      ram_raddr = acc_nxt;
    end else if (cmd.gen_start) begin
      ram_raddr = cmd.ks_init ? n_r : i_inc;
    end else if (cmd.gen_rd_j) begin
      ram_raddr = j_nxt;
    end else if (cmd.gen_wr_i) begin
      ram_raddr = t_nxt;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n_r;
    ram_wdata = n_r;
    if (cmd.fill) begin
      ram_we = 1'b1;
    end else if (cmd.ks_wr_n) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.ks_wr_a) begin
      ram_we    = 1'b1;
      ram_waddr = acc_r;
      ram_wdata = si_r;
    end else if (cmd.gen_wr_i) begin
      ram_we    = 1'b1;
      ram_waddr = i_r;
      ram_wdata = ram_rdata;
    end else if (cmd.gen_wr_j) begin
      ram_we    = 1'b1;
      ram_waddr = j_r;
      ram_wdata = si_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rc4_pkg::KEY_REGS; k++) begin
        key_r[k] <= '0;
      end
      key_len_r <= rc4_pkg::KEY_LEN_RESET;
      n_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      acc_r     <= '0;
      kpos_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rc4_pkg::REG_KEY0:    key_r[0]  <= cfg_wdata;
          rc4_pkg::REG_KEY1:    key_r[1]  <= cfg_wdata;
          rc4_pkg::REG_KEY2:    key_r[2]  <= cfg_wdata;
          rc4_pkg::REG_KEY3:    key_r[3]  <= cfg_wdata;
          rc4_pkg::REG_KEY_LEN: key_len_r <= cfg_wdata[LW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.ks_init) begin
        n_r    <= '0;
        i_r    <= '0;
        j_r    <= '0;
        acc_r  <= '0;
        kpos_r <= '0;
      end
      if (cmd.fill) begin
        n_r <= AW'(n_r + AW'(1));
      end
      if (cmd.ks_rd_a) begin
        acc_r <= acc_nxt;
      end
      if (cmd.ks_wr_a) begin
        n_r <= AW'(n_r + AW'(1));
        if (kpos_inc >= len_eff) begin
          kpos_r <= '0;
        end else begin
          kpos_r <= KPOS_W'(kpos_inc);
        end
      end
      if (cmd.gen_start && !cmd.ks_init) begin
        i_r <= i_inc;
      end
      if (cmd.gen_rd_j) begin
        j_r <= j_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      data_r <= in_data_byte;
    end
    if (cmd.ks_rd_a || cmd.gen_rd_j) begin
      si_r <= ram_rdata;
    end
    if (cmd.gen_wr_i) begin
      sj_r <= ram_rdata;
      t_r  <= t_nxt;
    end
    if (cmd.gen_wr_j) begin
      ks_r <= ks_comb;
    end
    if (cmd.out_load) begin
      out_byte_r <= data_r ^ (cmd.out_from_hold ? ks_r : ks_comb);
    end
  end

  assign out_byte = out_byte_r;

endmodule
